/* rtl/upi_pkg.sv */
// Shared types and constants for the unicycle pose integrator.
// No dependencies; the core, upi_mul and upi_cordic import this package.
package upi_pkg;

    // Command codes
    localparam logic [1:0] CMD_SET_VEL = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [1:0] CFG_START_X   = 2'd1;
    localparam logic [1:0] CFG_START_Y   = 2'd2;

    localparam logic [15:0] STEP_TIME_RST = 16'd6554;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 16;
    localparam int IT_W         = 4;
    localparam int CX_W         = 34;   // Q2.30 plus headroom
    localparam int CZ_W         = 19;   // 1/131072 turn units plus headroom
    localparam int CA_W         = 17;   // CORDIC angle width
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
    } upi_cmd_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading_angle;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] linear_echo;
        logic signed [15:0] angular_echo;
    } upi_pose_t;

    typedef struct packed {
        logic            start;
        logic [CA_W-1:0] angle;
    } upi_cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
    } upi_cordic_rsp_t;

    // Arctangent of 2^-i in 1/131072 turn units
    function automatic logic [14:0] atan_lut(input logic [IT_W-1:0] i);
        logic [14:0] r;
        case (i)
            4'd0:    r = 15'd16384;
            4'd1:    r = 15'd9672;
            4'd2:    r = 15'd5110;
            4'd3:    r = 15'd2594;
            4'd4:    r = 15'd1302;
            4'd5:    r = 15'd652;
            4'd6:    r = 15'd326;
            4'd7:    r = 15'd163;
            4'd8:    r = 15'd81;
            4'd9:    r = 15'd41;
            4'd10:   r = 15'd20;
            4'd11:   r = 15'd10;
            4'd12:   r = 15'd5;
            4'd13:   r = 15'd3;
            4'd14:   r = 15'd1;
            default: r = 15'd1;
        endcase
        return r;
    endfunction

endpackage

/* rtl/upi_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
// Payload type comes from upi_pkg structs at instantiation.
interface upi_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/unicycle_pose_integrator_core.sv */
// Top level: command sequencer, pose state and config registers.
// Depends on upi_pkg, upi_stream_if, upi_mul and upi_cordic.
//
//  Port     | Dir    | Payload     | Beat
//  cmd_ch   | sink   | upi_cmd_t   | one command
//  pose_ch  | source | upi_pose_t  | one pose after a time step
//  cfg_*    | in     | index, data | one register write
//
// Set-velocity, restart and unused commands complete without leaving the idle state.
// A time step runs two CORDIC passes (16 iterations, round, done) plus six
// non-waiting states around the five passes of the shared multiplier.
// cmd_ch is ready only between commands; a pending result beat waits in the
// output register, and a new step stalls at its end until that beat is taken.
// Reset clears the pose, held velocities and config to their start values.
module unicycle_pose_integrator_core
    import upi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    upi_stream_if.sink        cmd_ch,
    upi_stream_if.source      pose_ch,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_H  = 3'd1;
    localparam logic [2:0] ST_HEAD   = 3'd2;
    localparam logic [2:0] ST_TRIG1  = 3'd3;
    localparam logic [2:0] ST_MUL_S  = 3'd4;
    localparam logic [2:0] ST_MUL_XT = 3'd5;
    localparam logic [2:0] ST_POS_X  = 3'd6;
    localparam logic [2:0] ST_POS_Y  = 3'd7;
    localparam logic [3:0] ST_TRIG2  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [15:0]        step_time_reg;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg, heading_next;
    logic signed [15:0] lin_reg, ang_reg;
    logic signed [31:0] pc_reg, ps_reg;
    logic               out_valid_reg;
    upi_pose_t          pose_reg;

    logic               acc;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] prod;
    logic [48:0]        hp;
    logic signed [48:0] rp;
    logic signed [25:0] dpos;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat, pos_cur;
    logic               out_free;

    upi_cordic_req_t    cq;
    upi_cordic_rsp_t    cr;

    upi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    upi_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cq),
        .rsp   (cr)
    );

    assign acc      = cmd_ch.valid && cmd_ch.ready;
    assign out_free = !out_valid_reg || pose_ch.ready;

    assign cmd_ch.ready  = (state_reg == {1'b0, ST_IDLE});
    assign pose_ch.valid = out_valid_reg;
    assign pose_ch.data  = pose_reg;

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            {1'b0, ST_TRIG1}:
            begin
                mul_a = 32'(lin_reg);
                mul_b = 17'(cr.cs);
            end
            {1'b0, ST_MUL_S}:
            begin
                mul_a = 32'(lin_reg);
                mul_b = 17'(cr.sn);
            end
            {1'b0, ST_MUL_XT}:
            begin
                mul_a = pc_reg;
                mul_b = {1'b0, step_time_reg};
            end
            {1'b0, ST_POS_X}:
            begin
                mul_a = ps_reg;
                mul_b = {1'b0, step_time_reg};
            end
            default:
            begin
                mul_a = 32'(ang_reg);
                mul_b = {1'b0, step_time_reg};
            end
        endcase
    end

    // Heading increment rounded half up, wraps at a full turn
    always_comb
    begin
        hp           = prod + 49'd32768;
        heading_next = heading_reg + hp[31:16];
    end

    // Position increment: scale 2^39 down to Q16.16, saturating add
    always_comb
    begin
        pos_cur = (state_reg == {1'b0, ST_POS_X}) ? pos_x_reg : pos_y_reg;
        rp      = prod + 49'sh400000;
        dpos    = rp[48:23];
        pos_sum = 33'(pos_cur) + 33'(dpos);
        if (pos_sum[32] != pos_sum[31])
            pos_sat = pos_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            pos_sat = pos_sum[31:0];
    end

    always_comb
    begin
        cq.start = (state_reg == {1'b0, ST_HEAD}) || (state_reg == {1'b0, ST_POS_Y});
        if (state_reg == {1'b0, ST_HEAD})
            cq.angle = {heading_next, 1'b0};
        else
            cq.angle = {1'b0, heading_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            {1'b0, ST_IDLE}:
                if (acc && cmd_ch.data.command == CMD_STEP)
                    state_next = {1'b0, ST_MUL_H};
            {1'b0, ST_MUL_H}:  state_next = {1'b0, ST_HEAD};
            {1'b0, ST_HEAD}:   state_next = {1'b0, ST_TRIG1};
            {1'b0, ST_TRIG1}:
                if (cr.done)
                    state_next = {1'b0, ST_MUL_S};
            {1'b0, ST_MUL_S}:  state_next = {1'b0, ST_MUL_XT};
            {1'b0, ST_MUL_XT}: state_next = {1'b0, ST_POS_X};
            {1'b0, ST_POS_X}:  state_next = {1'b0, ST_POS_Y};
            {1'b0, ST_POS_Y}:  state_next = ST_TRIG2;
            ST_TRIG2:
                if (cr.done && out_free)
                    state_next = {1'b0, ST_IDLE};
            default:           state_next = {1'b0, ST_IDLE};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= {1'b0, ST_IDLE};
            step_time_reg <= STEP_TIME_RST;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            lin_reg       <= '0;
            ang_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_TIME: step_time_reg <= cfg_data[15:0];
                    CFG_START_X:   start_x_reg   <= cfg_data;
                    CFG_START_Y:   start_y_reg   <= cfg_data;
                    default:       ;
                endcase
            end

            if (acc && cmd_ch.data.command == CMD_SET_VEL)
            begin
                lin_reg <= cmd_ch.data.linear_velocity;
                ang_reg <= cmd_ch.data.angular_velocity;
            end

            if (acc && cmd_ch.data.command == CMD_RESTART)
            begin
                pos_x_reg   <= start_x_reg;
                pos_y_reg   <= start_y_reg;
                heading_reg <= '0;
            end

            if (state_reg == {1'b0, ST_HEAD})
                heading_reg <= heading_next;
            if (state_reg == {1'b0, ST_POS_X})
                pos_x_reg <= pos_sat;
            if (state_reg == {1'b0, ST_POS_Y})
                pos_y_reg <= pos_sat;

            if (state_reg == ST_TRIG2 && cr.done && out_free)
                out_valid_reg <= 1'b1;
            else if (pose_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == {1'b0, ST_MUL_S})
            pc_reg <= prod[31:0];
        if (state_reg == {1'b0, ST_MUL_XT})
            ps_reg <= prod[31:0];
        if (state_reg == ST_TRIG2 && cr.done && out_free)
        begin
            pose_reg.pos_x         <= pos_x_reg;
            pose_reg.pos_y         <= pos_y_reg;
            pose_reg.heading_angle <= heading_reg;
            pose_reg.quat_z        <= cr.sn;
            pose_reg.quat_w        <= cr.cs;
            pose_reg.linear_echo   <= lin_reg;
            pose_reg.angular_echo  <= ang_reg;
        end
    end

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd_ch.data.command == CMD_STEP) |=> state_reg == {1'b0, ST_MUL_H})
        else $error("time step did not start the sequence");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_TRIG2)
        else $error("result beat raised outside the final state");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd_ch.data.command == CMD_RESTART)
        |=> heading_reg == '0 && pos_x_reg == $past(start_x_reg)
            && pos_y_reg == $past(start_y_reg))
        else $error("restart did not reload the start pose");

    a_heading_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heading_reg) |-> $past(state_reg) == {1'b0, ST_HEAD}
            || ($past(acc) && $past(cmd_ch.data.command) == CMD_RESTART))
        else $error("heading changed outside a step or restart");

endmodule

/* rtl/upi_mul.sv */
// Shared signed multiplier, 32 x 17 bits, product registered.
// Depends on upi_pkg.
module upi_mul
    import upi_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [16:0] b,
    output logic signed [48:0] p
);

    logic signed [48:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 49'(a) * 49'(b);
    end

    assign p = p_reg;

endmodule

/* rtl/upi_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Returns sine and cosine in Q1.15; depends on upi_pkg.
module upi_cordic
    import upi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  upi_cordic_req_t req,
    output upi_cordic_rsp_t rsp
);

    logic signed [CX_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    logic [IT_W-1:0]        it_reg;
    logic                   run_reg, fin_reg, done_reg, flip_reg;
    logic signed [15:0]     sn_reg, cs_reg;

    logic signed [CA_W:0]   a_ext, a_fold;
    logic                   flip_in;
    logic signed [CX_W-1:0] dx, dy, xf, yf;
    logic signed [CZ_W-1:0] at;

    function automatic logic signed [15:0] to_q15(input logic signed [CX_W-1:0] v);
        logic signed [CX_W:0]    t;
        logic signed [CX_W-15:0] r;
        logic signed [15:0]      q;
        t = {v[CX_W-1], v} + (CX_W+1)'(16384);
        r = t[CX_W:15];
        if (r > (CX_W-14)'(32767))
            q = 16'sd32767;
        else if (r < -(CX_W-14)'(32768))
            q = -16'sd32768;
        else
            q = r[15:0];
        return q;
    endfunction

    // Fold to [-quarter, +quarter] turn; outside that, rotate by a half turn
    always_comb
    begin
        a_ext   = {req.angle[CA_W-1], req.angle};
        a_fold  = a_ext;
        flip_in = 1'b0;
        if (a_ext > (CA_W+1)'(32768))
        begin
            a_fold  = a_ext - (CA_W+1)'(65536);
            flip_in = 1'b1;
        end
        else if (a_ext < -(CA_W+1)'(32768))
        begin
            a_fold  = a_ext + (CA_W+1)'(65536);
            flip_in = 1'b1;
        end
    end

    always_comb
    begin
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        at = CZ_W'(atan_lut(it_reg));
        if (!z_reg[CZ_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (run_reg)
        begin
            it_reg <= it_reg + 1'b1;
            if (it_reg == IT_W'(CORDIC_ITERS - 1))
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= CZ_W'(a_fold);
            flip_reg <= flip_in;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            sn_reg <= to_q15(yf);
            cs_reg <= to_q15(xf);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sn   = sn_reg;
    assign rsp.cs   = cs_reg;

    a_run_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && (fin_reg || done_reg)))
        else $error("cordic run overlaps finish");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> run_reg && !done_reg && it_reg == '0)
        else $error("cordic start did not launch iterations");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(fin_reg))
        else $error("cordic done without finish stage");

endmodule
